>>> design/itoa_pkg.sv
// Shared constants, types and a helper function of the integer to ASCII converter.
package itoa_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int STEP_BITS       = 8;
	localparam int RADIX_W         = 8;
	localparam int CHAR_W          = 8;

	localparam logic [RADIX_W-1:0] RADIX_MIN = 8'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 8'd16;
	localparam logic [RADIX_W-1:0] RADIX_DEC = 8'd10;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_UPPER = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_ERR   = 8'h00;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SIGN,
		ST_FETCH,
		ST_EMIT,
		ST_ERR
	} ctrl_state_t;

	typedef enum logic [1:0] {
		OUT_DIGIT,
		OUT_SIGN,
		OUT_ERR
	} out_sel_t;

	typedef struct packed {
		logic     load;
		logic     step;
		logic     out_load;
		out_sel_t out_sel;
		logic     ptr_dec;
	} itoa_cmd_t;

	typedef struct packed {
		logic in_bad;
		logic div_last;
		logic div_done;
		logic neg;
		logic ptr_zero;
		logic out_free;
	} itoa_status_t;

	function automatic logic [CHAR_W-1:0] glyph(input logic [3:0] digit);
		logic [CHAR_W-1:0] d8;
		d8 = {4'b0000, digit};
		if (digit < 4'd10) begin
			return CHAR_ZERO + d8;
		end else begin
			return CHAR_UPPER + d8 - 8'd10;
		end
	endfunction

endpackage

>>> design/itoa_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module itoa_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> design/itoa_ctrl.sv
// Controller state machine sequencing division, sign, digit drain and error items.
module itoa_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  itoa_pkg::itoa_status_t status,
	output itoa_pkg::itoa_cmd_t    cmd
);

	itoa_pkg::ctrl_state_t state_q;
	itoa_pkg::ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itoa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			itoa_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_d = status.in_bad ? itoa_pkg::ST_ERR : itoa_pkg::ST_DIV;
				end
			end
			itoa_pkg::ST_DIV: begin
				if (status.div_last && status.div_done) begin
					state_d = status.neg ? itoa_pkg::ST_SIGN : itoa_pkg::ST_FETCH;
				end
			end
			itoa_pkg::ST_SIGN: begin
				if (status.out_free) begin
					state_d = itoa_pkg::ST_FETCH;
				end
			end
			itoa_pkg::ST_FETCH: begin
				state_d = itoa_pkg::ST_EMIT;
			end
			itoa_pkg::ST_EMIT: begin
				if (status.out_free) begin
					state_d = status.ptr_zero ? itoa_pkg::ST_IDLE : itoa_pkg::ST_FETCH;
				end
			end
			itoa_pkg::ST_ERR: begin
				if (status.out_free) begin
					state_d = itoa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = itoa_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready     = 1'b0;
		cmd.load     = 1'b0;
		cmd.step     = 1'b0;
		cmd.out_load = 1'b0;
		cmd.out_sel  = itoa_pkg::OUT_DIGIT;
		cmd.ptr_dec  = 1'b0;
		unique case (state_q)
			itoa_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			itoa_pkg::ST_DIV: begin
				cmd.step = 1'b1;
			end
			itoa_pkg::ST_SIGN: begin
				cmd.out_load = status.out_free;
				cmd.out_sel  = itoa_pkg::OUT_SIGN;
			end
			itoa_pkg::ST_FETCH: begin
				cmd.out_load = 1'b0;
			end
			itoa_pkg::ST_EMIT: begin
				cmd.out_load = status.out_free;
				cmd.out_sel  = itoa_pkg::OUT_DIGIT;
				cmd.ptr_dec  = status.out_free && !status.ptr_zero;
			end
			itoa_pkg::ST_ERR: begin
				cmd.out_load = status.out_free;
				cmd.out_sel  = itoa_pkg::OUT_ERR;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

endmodule

>>> design/itoa_dpath.sv
// Datapath: input decode, chunked radix divider, digit store and output register.
module itoa_dpath #(
	parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF,
	parameter int S_DATA_W    = 48
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [S_DATA_W-1:0]      s_tdata,
	input  logic                     m_tready,
	output logic                     m_tvalid,
	output logic [7:0]               m_tdata,
	output logic                     m_tlast,
	output logic                     m_tuser,
	input  itoa_pkg::itoa_cmd_t      cmd,
	output itoa_pkg::itoa_status_t   status
);

	localparam int STEP = itoa_pkg::STEP_BITS;
	localparam int NCH  = (VALUE_WIDTH + STEP - 1) / STEP;
	localparam int PW   = NCH * STEP;
	localparam int CHW  = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int AW   = $clog2(VALUE_WIDTH);
	localparam int CNW  = $clog2(VALUE_WIDTH + 1);

	logic [VALUE_WIDTH-1:0]           in_value;
	logic [itoa_pkg::RADIX_W-1:0]     in_radix;
	logic                             in_op;
	logic                             in_neg;
	logic [VALUE_WIDTH-1:0]           in_mag;

	logic [PW-1:0]                    quot_q;
	logic [3:0]                       rem_q;
	logic [4:0]                       radix_q;
	logic                             neg_q;
	logic [CHW-1:0]                   chunk_q;
	logic [CNW-1:0]                   count_q;
	logic [AW-1:0]                    ptr_q;

	logic [PW-1:0]                    quot_next;
	logic [3:0]                       rem_next;
	logic [STEP-1:0]                  qbits;
	logic [PW+STEP-1:0]               quot_cat;
	logic                             write_digit;
	logic [3:0]                       rd_digit;

	logic                             out_valid_q;
	logic [7:0]                       out_char_q;
	logic                             out_last_q;
	logic                             out_bad_q;

	assign in_value = s_tdata[VALUE_WIDTH-1:0];
	assign in_radix = s_tdata[VALUE_WIDTH+itoa_pkg::RADIX_W-1:VALUE_WIDTH];
	assign in_op    = s_tdata[VALUE_WIDTH+itoa_pkg::RADIX_W];
	assign in_neg   = in_op && (in_radix == itoa_pkg::RADIX_DEC) && in_value[VALUE_WIDTH-1];
	assign in_mag   = in_neg ? (~in_value + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : in_value;

	always_comb begin
		logic [4:0] t;
		logic [3:0] r;
		r = rem_q;
		qbits = '0;
		for (int j = 0; j < STEP; j++) begin
			t = {r, quot_q[PW-1-j]};
			if (t >= radix_q) begin
				t = t - radix_q;
				qbits[STEP-1-j] = 1'b1;
			end
			r = t[3:0];
		end
		rem_next = r;
		quot_cat = {quot_q, qbits};
		quot_next = quot_cat[PW-1:0];
	end

	assign write_digit = cmd.step && status.div_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quot_q  <= '0;
			rem_q   <= '0;
			radix_q <= '0;
			neg_q   <= 1'b0;
			chunk_q <= '0;
			count_q <= '0;
			ptr_q   <= '0;
		end else if (cmd.load) begin
			quot_q  <= PW'(in_mag);
			rem_q   <= '0;
			radix_q <= in_radix[4:0];
			neg_q   <= in_neg;
			chunk_q <= '0;
			count_q <= '0;
		end else if (cmd.step) begin
			quot_q <= quot_next;
			if (status.div_last) begin
				rem_q   <= '0;
				chunk_q <= '0;
				count_q <= count_q + CNW'(1);
				ptr_q   <= count_q[AW-1:0];
			end else begin
				rem_q   <= rem_next;
				chunk_q <= chunk_q + CHW'(1);
			end
		end else if (cmd.ptr_dec) begin
			ptr_q <= ptr_q - AW'(1);
		end
	end

	itoa_ram #(
		.WIDTH(4),
		.DEPTH(VALUE_WIDTH)
	) u_digits (
		.clk  (clk),
		.we   (write_digit),
		.waddr(count_q[AW-1:0]),
		.wdata(rem_next),
		.raddr(ptr_q),
		.rdata(rd_digit)
	);

	assign status.in_bad   = (in_radix < itoa_pkg::RADIX_MIN) || (in_radix > itoa_pkg::RADIX_MAX);
	assign status.div_last = (chunk_q == CHW'(NCH - 1));
	assign status.div_done = (quot_next == '0) || (count_q == CNW'(VALUE_WIDTH - 1));
	assign status.neg      = neg_q;
	assign status.ptr_zero = (ptr_q == '0);
	assign status.out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			unique case (cmd.out_sel)
				itoa_pkg::OUT_DIGIT: begin
					out_char_q <= itoa_pkg::glyph(rd_digit);
					out_last_q <= status.ptr_zero;
					out_bad_q  <= 1'b0;
				end
				itoa_pkg::OUT_SIGN: begin
					out_char_q <= itoa_pkg::CHAR_MINUS;
					out_last_q <= 1'b0;
					out_bad_q  <= 1'b0;
				end
				itoa_pkg::OUT_ERR: begin
					out_char_q <= itoa_pkg::CHAR_ERR;
					out_last_q <= 1'b1;
					out_bad_q  <= 1'b1;
				end
				default: begin
					out_char_q <= itoa_pkg::CHAR_ERR;
					out_last_q <= 1'b1;
					out_bad_q  <= 1'b1;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_char_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_bad_q;

endmodule

>>> design/integer_to_ascii_radix_unit.sv
// Top level of the integer to ASCII converter for bases 2 to 16.
//
//  channel | dir | payload
//  --------+-----+---------------------------------------------------------
//  s_*     | in  | tdata: value_bits, radix, operation (zero pad to bytes)
//  m_*     | out | tdata: character; tlast: last_char; tuser: bad_radix
//
// One item at a time. Each digit is one pass of the divider over all 8-bit chunks
// of the quotient, and the divider retires 8 quotient bits per cycle. Each character
// then passes the FETCH and EMIT states through the registered digit RAM read port;
// a minus sign, if any, goes out first from the SIGN state. A bad radix gives one item.
// No clearing pass after reset; m_tready low holds the output register and the drain.
module integer_to_ascii_radix_unit #(
	parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         s_tvalid,
	output logic                                         s_tready,
	// value_bits, radix, operation, zero pad
	input  logic [((VALUE_WIDTH+itoa_pkg::RADIX_W+1+7)/8)*8-1:0] s_tdata,
	output logic                                         m_tvalid,
	input  logic                                         m_tready,
	// character
	output logic [7:0]                                   m_tdata,
	output logic                                         m_tlast,
	// bad_radix
	output logic                                         m_tuser
);

	localparam int S_DATA_W = ((VALUE_WIDTH + itoa_pkg::RADIX_W + 1 + 7) / 8) * 8;

	itoa_pkg::itoa_cmd_t    cmd;
	itoa_pkg::itoa_status_t status;

	itoa_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.status  (status),
		.cmd     (cmd)
	);

	itoa_dpath #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.S_DATA_W   (S_DATA_W)
	) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.m_tready(m_tready),
		.m_tvalid(m_tvalid),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser),
		.cmd     (cmd),
		.status  (status)
	);

endmodule
